// ===== sv/hdlc_frame_receiver_defines.svh =====
// Assertion macros shared by the HDLC frame receiver RTL.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef HDLC_FRAME_RECEIVER_DEFINES_SVH
`define HDLC_FRAME_RECEIVER_DEFINES_SVH

// Whenever ante holds at a clock edge out of reset, cons must hold at the same edge.
`define HFR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hdlc_frame_receiver: same-cycle check failed");

// Whenever ante holds at a clock edge out of reset, cons must hold at the next edge.
`define HFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hdlc_frame_receiver: next-cycle check failed");

`endif

// ===== sv/hfr_pkg.sv =====
// Shared constants and types for the HDLC frame receiver.
// Used by hfr_rx_core, hfr_out_serializer and hdlc_frame_receiver; no dependencies.
`default_nettype none

package hfr_pkg;

   localparam int unsigned MAX_PAYLOAD_DEFAULT = 1024;

   // Line bytes.
   localparam logic [7:0] FLAG_BYTE  = 8'h7E;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_FLAG   = 8'h5E;
   localparam logic [7:0] ESC_ESC    = 8'h5D;
   localparam logic [7:0] CTRL_SEQ0  = 8'h00;
   localparam logic [7:0] CTRL_SEQ1  = 8'h40;
   localparam logic [7:0] REPLY_ADDR = 8'h03;
   localparam logic [7:0] CTRL_RR0   = 8'h05;
   localparam logic [7:0] CTRL_RR1   = 8'h85;
   localparam logic [7:0] CTRL_REJ0  = 8'h01;
   localparam logic [7:0] CTRL_REJ1  = 8'h81;

   // Frame status codes reported on reply bytes.
   localparam logic [2:0] ST_ACCEPTED   = 3'd0;
   localparam logic [2:0] ST_DUPLICATE  = 3'd1;
   localparam logic [2:0] ST_HEADER_ERR = 3'd2;
   localparam logic [2:0] ST_DATA_ERR   = 3'd3;
   localparam logic [2:0] ST_BAD_CTRL   = 3'd4;

   // Everything one received byte produces: up to two payload bytes and
   // optionally a five-byte reply frame.
   typedef struct packed {
      logic [1:0] pay_cnt;
      logic [7:0] pay0;
      logic [7:0] pay1;
      logic       reply;
      logic [2:0] status;
      logic [7:0] ctrl;
   } bundle_type;

endpackage

`default_nettype wire

// ===== sv/hdlc_frame_receiver.sv =====
// HDLC frame receiver top level: parser core plus output serializer.
// Depends on hfr_pkg, hfr_rx_core, hfr_out_serializer and hdlc_frame_receiver_defines.svh.
//
// The receiver takes one raw line byte per item on the req_ channel and hunts for
// 0x7E flags. Inside a frame it checks the header check byte (address XOR control),
// removes 0x7D escapes and delivers payload bytes one byte late, since the last
// destuffed byte of a frame is the data check byte. On the closing flag it sends a
// five-byte RR or REJ reply on the rsp_ channel, with rsp_frame_status telling the
// outcome and rsp_reply_last on the final byte. A frame whose sequence bit does not
// match the expected one is acknowledged but not delivered. An item that causes at
// most one result is taken every cycle while rsp_stall is low; an item that causes k
// results holds the single output register until all k have gone (two for a bad escape
// that yields two payload bytes, five or six for a closing flag), so req_stall is raised
// until the last of those results moves into the output register. The core handles each
// byte combinationally; the serializer sets the rate, one result per unstalled cycle.
`default_nettype none

`include "hdlc_frame_receiver_defines.svh"

module hdlc_frame_receiver #(
   parameter int unsigned MAX_PAYLOAD = hfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_out_kind,
   output logic [7:0]      rsp_out_byte,
   output logic [2:0]      rsp_frame_status,
   output logic            rsp_reply_last
);

   hfr_pkg::bundle_type bundle;
   logic                ser_ready;
   logic                req_accept;

   // An item is taken only when the result register can hold all it produces.
   assign req_stall  = !ser_ready;
   assign req_accept = req_valid && ser_ready;

   // Parser: state registers updated once per accepted byte.
   hfr_rx_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .load   (req_accept),
      .rx_byte(req_rx_byte),
      .bundle (bundle)
   );

   // Result register and output register.
   hfr_out_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .bundle_in (bundle),
      .ready     (ser_ready),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_kind  (rsp_out_kind),
      .out_byte  (rsp_out_byte),
      .out_status(rsp_frame_status),
      .out_last  (rsp_reply_last)
   );

   // Payload bytes never carry a status or the end-of-reply mark.
   `HFR_ASSERT_SAME(a_payload_clean, rsp_valid && !rsp_out_kind,
                    rsp_frame_status == hfr_pkg::ST_ACCEPTED && !rsp_reply_last)

   // While a reply byte other than the last is held back, the rest of that reply
   // is still queued, so no new byte may be taken.
   `HFR_ASSERT_SAME(a_reply_blocks_input,
                    rsp_valid && rsp_stall && rsp_out_kind && !rsp_reply_last,
                    req_stall)

   // Status codes on replies stay within the defined set.
   `HFR_ASSERT_SAME(a_status_range, rsp_valid && rsp_out_kind,
                    rsp_frame_status == hfr_pkg::ST_ACCEPTED ||
                    rsp_frame_status == hfr_pkg::ST_DUPLICATE ||
                    rsp_frame_status == hfr_pkg::ST_HEADER_ERR ||
                    rsp_frame_status == hfr_pkg::ST_DATA_ERR ||
                    rsp_frame_status == hfr_pkg::ST_BAD_CTRL)

endmodule

`default_nettype wire

// ===== sv/hfr_rx_core.sv =====
// Per-byte frame parser: header check, destuffing, hold-back and reply decision.
// Depends on hfr_pkg.
`default_nettype none

module hfr_rx_core #(
   parameter int unsigned MAX_PAYLOAD = hfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic [7:0]        rx_byte,
   output hfr_pkg::bundle_type    bundle
);

   localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);
   localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PAYLOAD);

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_ADDR = 3'd1;
   localparam logic [2:0] PH_CTRL = 3'd2;
   localparam logic [2:0] PH_BCC1 = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_OVER = 3'd5;
   localparam logic [2:0] PH_BADH = 3'd6;

   typedef struct packed {
      logic [2:0]      phase;
      logic [7:0]      addr;
      logic [7:0]      ctrl;
      logic            esc;
      logic [7:0]      held;
      logic            held_v;
      logic [7:0]      xsum;
      logic [CntW-1:0] cnt;
      logic            seq;
   } state_type;

   typedef struct packed {
      state_type  st;
      logic       emit;
      logic [7:0] data;
   } push_type;

   function automatic state_type clear_data(state_type s);
      state_type r;
      r = s;
      r.esc    = 1'b0;
      r.held   = 8'h00;
      r.held_v = 1'b0;
      r.xsum   = 8'h00;
      r.cnt    = '0;
      return r;
   endfunction

   // One destuffed byte enters; the byte held before it becomes payload.
   function automatic push_type do_push(state_type s, logic [7:0] d);
      push_type r;
      logic     deliver;
      deliver = (s.ctrl == hfr_pkg::CTRL_SEQ0 && !s.seq) ||
                (s.ctrl == hfr_pkg::CTRL_SEQ1 && s.seq);
      r.st   = s;
      r.emit = 1'b0;
      r.data = s.held;
      if (s.held_v && s.cnt >= MaxCnt) begin
         r.st.phase = PH_OVER;
      end else begin
         if (s.held_v) begin
            r.emit    = deliver;
            r.st.xsum = s.xsum ^ s.held;
            r.st.cnt  = s.cnt + CntW'(1);
         end
         r.st.held   = d;
         r.st.held_v = 1'b1;
      end
      return r;
   endfunction

   state_type  state_ff;
   state_type  state_in;
   push_type   pa;
   push_type   pb;
   logic       run_b;
   logic [2:0] status;
   logic [7:0] ctrl_c;
   logic       reply;

   always_comb begin
      state_in = state_ff;
      pa       = '0;
      pb       = '0;
      run_b    = 1'b0;
      status   = hfr_pkg::ST_ACCEPTED;
      reply    = 1'b0;
      if (rx_byte == hfr_pkg::FLAG_BYTE) begin
         if (state_ff.phase == PH_HUNT || state_ff.phase == PH_ADDR) begin
            state_in       = clear_data(state_in);
            state_in.phase = PH_ADDR;
         end else begin
            // A dangling escape before the closing flag is a literal escape byte.
            if (state_in.phase == PH_DATA && state_in.esc) begin
               state_in.esc = 1'b0;
               pa           = do_push(state_in, hfr_pkg::ESC_BYTE);
               state_in     = pa.st;
            end
            if (state_in.phase == PH_CTRL || state_in.phase == PH_BCC1 ||
                state_in.phase == PH_BADH) begin
               status = hfr_pkg::ST_HEADER_ERR;
            end else if (state_in.phase == PH_OVER) begin
               status = hfr_pkg::ST_DATA_ERR;
            end else if (state_in.cnt == '0 || !state_in.held_v ||
                         state_in.xsum != state_in.held) begin
               status = hfr_pkg::ST_DATA_ERR;
            end else if (state_in.ctrl != hfr_pkg::CTRL_SEQ0 &&
                         state_in.ctrl != hfr_pkg::CTRL_SEQ1) begin
               status = hfr_pkg::ST_BAD_CTRL;
            end else if ((state_in.ctrl == hfr_pkg::CTRL_SEQ1) == state_in.seq) begin
               status       = hfr_pkg::ST_ACCEPTED;
               state_in.seq = ~state_in.seq;
            end else begin
               status = hfr_pkg::ST_DUPLICATE;
            end
            reply          = 1'b1;
            state_in       = clear_data(state_in);
            state_in.phase = PH_ADDR;
         end
      end else begin
         case (state_ff.phase)
            PH_ADDR: begin
               state_in.addr  = rx_byte;
               state_in.phase = PH_CTRL;
            end
            PH_CTRL: begin
               state_in.ctrl  = rx_byte;
               state_in.phase = PH_BCC1;
            end
            PH_BCC1: begin
               state_in       = clear_data(state_in);
               state_in.phase = (rx_byte == (state_ff.addr ^ state_ff.ctrl)) ?
                                PH_DATA : PH_BADH;
            end
            PH_DATA: begin
               run_b = 1'b1;
               if (state_ff.esc) begin
                  state_in.esc = 1'b0;
                  if (rx_byte == hfr_pkg::ESC_FLAG) begin
                     pa    = do_push(state_in, hfr_pkg::FLAG_BYTE);
                     run_b = 1'b0;
                  end else if (rx_byte == hfr_pkg::ESC_ESC) begin
                     pa    = do_push(state_in, hfr_pkg::ESC_BYTE);
                     run_b = 1'b0;
                  end else begin
                     // Bad escape: keep the escape byte, then treat this byte normally.
                     pa    = do_push(state_in, hfr_pkg::ESC_BYTE);
                     run_b = (pa.st.phase == PH_DATA);
                  end
                  state_in = pa.st;
               end
               if (run_b) begin
                  if (rx_byte == hfr_pkg::ESC_BYTE) begin
                     state_in.esc = 1'b1;
                  end else begin
                     pb       = do_push(state_in, rx_byte);
                     state_in = pb.st;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (status == hfr_pkg::ST_ACCEPTED || status == hfr_pkg::ST_DUPLICATE) begin
         ctrl_c = state_in.seq ? hfr_pkg::CTRL_RR1 : hfr_pkg::CTRL_RR0;
      end else begin
         ctrl_c = state_in.seq ? hfr_pkg::CTRL_REJ1 : hfr_pkg::CTRL_REJ0;
      end
   end

   assign bundle.pay_cnt = {1'b0, pa.emit} + {1'b0, pb.emit};
   assign bundle.pay0    = pa.emit ? pa.data : pb.data;
   assign bundle.pay1    = pb.data;
   assign bundle.reply   = reply;
   assign bundle.status  = status;
   assign bundle.ctrl    = ctrl_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         // The all-zero state is the hunt phase with every frame register cleared.
         state_ff <= '0;
      end else if (load) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/hfr_out_serializer.sv =====
// Result register and output register: sends a bundle's bytes one per unstalled cycle.
// Depends on hfr_pkg.
`default_nettype none

module hfr_out_serializer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire hfr_pkg::bundle_type bundle_in,
   output logic                     ready,
   output logic                     out_valid,
   input  wire logic                out_stall,
   output logic                     out_kind,
   output logic [7:0]               out_byte,
   output logic [2:0]               out_status,
   output logic                     out_last
);

   localparam logic [2:0] ReplyLen  = 3'd5;
   localparam logic [2:0] ReplyLast = 3'd4;

   hfr_pkg::bundle_type bundle_ff;
   logic [2:0]          pos_ff;
   logic [2:0]          total;
   logic [2:0]          ridx;
   logic                pending;
   logic                advance;
   logic                last_one;
   logic                head_kind;
   logic [7:0]          head_byte;
   logic [2:0]          head_status;
   logic                head_last;
   logic                out_valid_ff;
   logic                out_kind_ff;
   logic [7:0]          out_byte_ff;
   logic [2:0]          out_status_ff;
   logic                out_last_ff;

   assign total    = {1'b0, bundle_ff.pay_cnt} + (bundle_ff.reply ? ReplyLen : 3'd0);
   assign pending  = (pos_ff != total);
   assign advance  = pending && (!out_valid_ff || !out_stall);
   assign last_one = ((total - pos_ff) == 3'd1);
   assign ready    = !pending || (last_one && advance);
   assign ridx     = pos_ff - {1'b0, bundle_ff.pay_cnt};

   always_comb begin
      head_kind   = 1'b0;
      head_byte   = pos_ff[0] ? bundle_ff.pay1 : bundle_ff.pay0;
      head_status = hfr_pkg::ST_ACCEPTED;
      head_last   = 1'b0;
      if (pos_ff >= {1'b0, bundle_ff.pay_cnt}) begin
         head_kind   = 1'b1;
         head_status = bundle_ff.status;
         head_last   = (ridx == ReplyLast);
         case (ridx)
            3'd0:    head_byte = hfr_pkg::FLAG_BYTE;
            3'd1:    head_byte = hfr_pkg::REPLY_ADDR;
            3'd2:    head_byte = bundle_ff.ctrl;
            3'd3:    head_byte = hfr_pkg::REPLY_ADDR ^ bundle_ff.ctrl;
            default: head_byte = hfr_pkg::FLAG_BYTE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bundle_ff <= '0;
         pos_ff    <= 3'd0;
      end else if (load) begin
         bundle_ff <= bundle_in;
         pos_ff    <= 3'd0;
      end else if (advance) begin
         pos_ff <= pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!out_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_kind_ff   <= head_kind;
         out_byte_ff   <= head_byte;
         out_status_ff <= head_status;
         out_last_ff   <= head_last;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_kind   = out_kind_ff;
   assign out_byte   = out_byte_ff;
   assign out_status = out_status_ff;
   assign out_last   = out_last_ff;

endmodule

`default_nettype wire
